/* src/civ_pkg.sv */
// shared constants, types and codes for the cbor item validator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package civ_pkg;

    localparam int MAX_NEST  = 8;
    localparam int MAX_ITEMS = 64;

    localparam int DEPTH_W = 4;
    localparam int ITEMS_W = 7;
    localparam int CFG_W   = 7;
    localparam int IDX_W   = 2;
    localparam int OPEN_W  = $clog2(MAX_NEST + 1);
    localparam int LVL_W   = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int CNT_W   = 8;
    localparam int ARG_W   = 32;

    localparam logic [IDX_W-1:0] CFG_DEPTH_LIMIT = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_ITEM_LIMIT  = IDX_W'(1);

    localparam logic [2:0] MT_UINT  = 3'd0;
    localparam logic [2:0] MT_NINT  = 3'd1;
    localparam logic [2:0] MT_BYTES = 3'd2;
    localparam logic [2:0] MT_TEXT  = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;
    localparam logic [2:0] MT_MAP   = 3'd5;
    localparam logic [2:0] MT_TAG   = 3'd6;
    localparam logic [2:0] MT_OTHER = 3'd7;

    localparam logic [4:0] AI_ONE_BYTE = 5'd24;
    localparam logic [4:0] AI_TWO_BYTE = 5'd25;
    localparam logic [4:0] AI_RESERVED = 5'd27;

    typedef enum logic [3:0] {
        PH_HEAD    = 4'b0001,
        PH_ARG     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DISCARD = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_ERROR   = 2'd2,
        ST_DISCARD = 2'd3
    } t_status;

endpackage

`default_nettype wire

/* src/cbor_item_validator_unit.sv */
// Usage:
//   Bytes of a cbor buffer enter on the input channel (i_in_valid / o_in_ready),
//   one word per byte with i_last_byte set on the final byte of the buffer.
//   Every byte yields exactly one result word on the output channel
//   (o_out_valid / i_out_ready): o_status and o_open_depth.
//   An accepted byte sits in an input register, is decoded combinationally
//   against the parse state and lands in the result register once that
//   register is empty or being read by the receiver.
//   Throughput is one byte per cycle while i_out_ready is high; the container
//   close chain is one priority pick over the eight-entry child count stack.
//   When the receiver stalls the result register holds, the input register
//   fills and then o_in_ready drops; nothing is lost or repeated.
//   Reset (i_rst_n low at a clock edge) empties both registers, clears the
//   parse state and sets depth_limit to 8 and item_limit to 64.
//   Registers are written through i_cfg_we / i_cfg_index / i_cfg_data,
//   index 0 depth_limit and index 1 item_limit; other indexes are ignored.
// Depends on civ_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbor_item_validator_unit
    import civ_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_last_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_status,
    output logic [DEPTH_W-1:0]      o_open_depth,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    logic [DEPTH_W-1:0] r_depth_limit;
    logic [ITEMS_W-1:0] r_item_limit;

    logic               r_in_valid;
    logic [7:0]         r_byte;
    logic               r_last;

    logic               r_out_valid;
    t_status            r_status;
    logic [DEPTH_W-1:0] r_depth;

    t_phase             r_phase;
    logic [2:0]         r_head_major;
    logic [4:0]         r_head_info;
    logic [2:0]         r_arg_left;
    logic [ARG_W-1:0]   r_arg_value;
    logic [ARG_W-1:0]   r_payload_left;
    logic [OPEN_W-1:0]  r_open_levels;
    logic [CNT_W-1:0]   r_child_counts [MAX_NEST];

    t_phase             n_phase;
    logic [2:0]         n_head_major;
    logic [4:0]         n_head_info;
    logic [2:0]         n_arg_left;
    logic [ARG_W-1:0]   n_arg_value;
    logic [ARG_W-1:0]   n_payload_left;
    logic [OPEN_W-1:0]  n_open_levels;
    t_status            n_status;
    logic [DEPTH_W-1:0] n_depth;

    logic               cnt_we;
    logic [LVL_W-1:0]   cnt_idx;
    logic [CNT_W-1:0]   cnt_val;

    logic               advance;
    logic [OPEN_W:0]    nest_cap;
    logic [ITEMS_W:0]   count_cap;

    logic               pop_found;
    logic [LVL_W-1:0]   pop_idx;
    logic [OPEN_W-1:0]  pop_open;

    always_comb begin
        advance    = r_in_valid && (!r_out_valid || i_out_ready);
        o_in_ready = !r_in_valid || advance;
    end

    always_comb begin
        if ({1'b0, r_depth_limit} < (DEPTH_W + 1)'(MAX_NEST)) begin
            nest_cap = (OPEN_W + 1)'(r_depth_limit);
        end else begin
            nest_cap = (OPEN_W + 1)'(MAX_NEST);
        end
        if ({1'b0, r_item_limit} < (ITEMS_W + 1)'(MAX_ITEMS)) begin
            count_cap = {1'b0, r_item_limit};
        end else begin
            count_cap = (ITEMS_W + 1)'(MAX_ITEMS);
        end
    end

    // closing chain: the deepest open level whose count stays above zero
    always_comb begin
        pop_found = 1'b0;
        pop_idx   = '0;
        for (int i = 0; i < MAX_NEST; i++) begin
            if ((OPEN_W + 1)'(i) < {1'b0, r_open_levels} &&
                r_child_counts[i] > CNT_W'(1)) begin
                pop_found = 1'b1;
                pop_idx   = LVL_W'(i);
            end
        end
        pop_open = pop_found ? OPEN_W'({1'b0, pop_idx} + (LVL_W + 1)'(1)) : '0;
    end

    always_comb begin
        logic             ok;
        logic             item_done;
        logic             head_complete;
        logic [ARG_W-1:0] hval;
        logic [2:0]       cur_major;
        logic [2:0]       major;
        logic [4:0]       info;
        logic [ARG_W-1:0] av;
        logic [2:0]       left_dec;
        logic [ARG_W-1:0] pl_dec;

        n_phase        = r_phase;
        n_head_major   = r_head_major;
        n_head_info    = r_head_info;
        n_arg_left     = r_arg_left;
        n_arg_value    = r_arg_value;
        n_payload_left = r_payload_left;
        n_open_levels  = r_open_levels;
        n_status       = ST_BUSY;
        n_depth        = '0;
        cnt_we         = 1'b0;
        cnt_idx        = pop_idx;
        cnt_val        = r_child_counts[pop_idx] - CNT_W'(1);

        ok            = 1'b1;
        item_done     = 1'b0;
        head_complete = 1'b0;
        hval          = '0;
        cur_major     = r_head_major;
        major         = r_byte[7:5];
        info          = r_byte[4:0];
        av            = {r_arg_value[ARG_W-9:0], r_byte};
        left_dec      = (r_arg_left != 3'd0) ? r_arg_left - 3'd1 : 3'd0;
        pl_dec        = (r_payload_left != '0) ? r_payload_left - ARG_W'(1) : '0;

        case (r_phase)
            PH_HEAD: begin
                n_head_major = major;
                n_head_info  = info;
                cur_major    = major;
                if ({1'b0, r_open_levels} > nest_cap || major == MT_TAG ||
                    info >= AI_RESERVED ||
                    (major == MT_OTHER && info >= AI_ONE_BYTE)) begin
                    ok = 1'b0;
                end else if (info < AI_ONE_BYTE) begin
                    head_complete = 1'b1;
                    hval          = ARG_W'(info);
                end else begin
                    n_arg_left  = (info == AI_ONE_BYTE) ? 3'd1 :
                                  ((info == AI_TWO_BYTE) ? 3'd2 : 3'd4);
                    n_arg_value = '0;
                    n_phase     = PH_ARG;
                end
            end
            PH_ARG: begin
                n_arg_value = av;
                n_arg_left  = left_dec;
                if (left_dec == 3'd0) begin
                    if (r_head_info == AI_ONE_BYTE) begin
                        ok = av >= ARG_W'(24);
                    end else if (r_head_info == AI_TWO_BYTE) begin
                        ok = av > ARG_W'(16'h00ff);
                    end else begin
                        ok = av > ARG_W'(32'h0000_ffff);
                    end
                    head_complete = ok;
                    hval          = av;
                end
            end
            PH_PAYLOAD: begin
                n_payload_left = pl_dec;
                item_done      = (pl_dec == '0);
            end
            default: begin
                ok = 1'b1;
            end
        endcase

        if (head_complete) begin
            case (cur_major)
                MT_UINT, MT_NINT, MT_OTHER: begin
                    item_done = 1'b1;
                end
                MT_BYTES, MT_TEXT: begin
                    if (hval == '0) begin
                        item_done = 1'b1;
                    end else begin
                        n_payload_left = hval;
                        n_phase        = PH_PAYLOAD;
                    end
                end
                MT_ARRAY, MT_MAP: begin
                    if (hval > ARG_W'(count_cap)) begin
                        ok = 1'b0;
                    end else if (hval == '0) begin
                        item_done = 1'b1;
                    end else if ({1'b0, r_open_levels} >= nest_cap) begin
                        ok = 1'b0;
                    end else begin
                        cnt_we        = 1'b1;
                        cnt_idx       = r_open_levels[LVL_W-1:0];
                        cnt_val       = (cur_major == MT_MAP) ? {hval[CNT_W-2:0], 1'b0}
                                                              : hval[CNT_W-1:0];
                        n_open_levels = r_open_levels + OPEN_W'(1);
                        n_phase       = PH_HEAD;
                    end
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end

        if (item_done) begin
            n_phase       = PH_HEAD;
            n_open_levels = pop_open;
            cnt_we        = pop_found;
            cnt_idx       = pop_idx;
            cnt_val       = r_child_counts[pop_idx] - CNT_W'(1);
        end

        if (r_phase == PH_DISCARD) begin
            n_status = ST_DISCARD;
            if (r_last) begin
                n_phase       = PH_HEAD;
                n_open_levels = '0;
            end
        end else begin
            if (ok && r_last && (n_phase != PH_HEAD || n_open_levels != '0)) begin
                ok = 1'b0;
            end
            if (!ok) begin
                n_status      = ST_ERROR;
                n_open_levels = '0;
                n_phase       = r_last ? PH_HEAD : PH_DISCARD;
                cnt_we        = 1'b0;
            end else if (n_phase == PH_HEAD && n_open_levels == '0) begin
                n_status = ST_DONE;
            end else begin
                n_status = ST_BUSY;
                n_depth  = DEPTH_W'(n_open_levels);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_limit  <= DEPTH_W'(8);
            r_item_limit   <= ITEMS_W'(64);
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_HEAD;
            r_head_major   <= '0;
            r_head_info    <= '0;
            r_arg_left     <= '0;
            r_arg_value    <= '0;
            r_payload_left <= '0;
            r_open_levels  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEPTH_LIMIT: r_depth_limit <= i_cfg_data[DEPTH_W-1:0];
                    CFG_ITEM_LIMIT:  r_item_limit  <= i_cfg_data[ITEMS_W-1:0];
                    default: begin
                        r_depth_limit <= r_depth_limit;
                    end
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_phase        <= n_phase;
                r_head_major   <= n_head_major;
                r_head_info    <= n_head_info;
                r_arg_left     <= n_arg_left;
                r_arg_value    <= n_arg_value;
                r_payload_left <= n_payload_left;
                r_open_levels  <= n_open_levels;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (advance) begin
            r_status <= n_status;
            r_depth  <= n_depth;
            if (cnt_we) begin
                r_child_counts[cnt_idx] <= cnt_val;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_open_depth = r_depth;

endmodule

`default_nettype wire
